FILE: rtl/assert_macros.svh
// Assertion macros shared by the scaler RTL files.
// Depends on nothing; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed: invariant violated");
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle check violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: rtl/nns_pkg.sv
// Package for the nearest-neighbor scaler: sizes, word types, register codes
// and the configuration clamping functions. Depends on nothing.
package nns_pkg;

   localparam int MAX_SRC_DIM = 512;
   localparam int MAX_OUT_DIM = 1023;
   localparam int MIN_DIM     = 2;

   localparam int CFG_W   = 10;
   localparam int COORD_W = 10;
   localparam int PIX_W   = 8;

   localparam int SRC_W       = $clog2(MAX_SRC_DIM);
   localparam int OUT_W       = $clog2(MAX_OUT_DIM);
   localparam int PROD_W      = OUT_W + SRC_W;
   localparam int NUM_W       = PROD_W + 1;
   localparam int DEN_W       = OUT_W + 1;
   localparam int STORE_DEPTH = MAX_SRC_DIM * MAX_SRC_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   localparam int LANES    = 2;
   localparam int LANE_ROW = 0;
   localparam int LANE_COL = 1;

   localparam int SRC_RESET = 512;
   localparam int OUT_RESET = 768;

   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SRC_WIDTH  = 3'd0,
      CSR_SRC_HEIGHT = 3'd1,
      CSR_OUT_WIDTH  = 3'd2,
      CSR_OUT_HEIGHT = 3'd3
   } csr_index_type;

   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_READ = 1'b1;

   typedef struct packed {
      logic               action;
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] col;
      logic [PIX_W-1:0]   pixel_in;
   } nns_req_type;

   typedef struct packed {
      logic [PIX_W-1:0] pixel_out;
      logic [SRC_W-1:0] src_row_used;
      logic [SRC_W-1:0] src_col_used;
   } nns_rsp_type;

   typedef struct packed {
      logic              valid;
      logic              is_load;
      logic              wr_ok;
      logic [ADDR_W-1:0] waddr;
      logic [PIX_W-1:0]  pixel;
   } nns_side_type;

   typedef struct packed {
      logic [OUT_W-1:0] o;
      logic [SRC_W-1:0] sm1;
      logic [OUT_W-1:0] span;
   } nns_lane_type;

   function automatic logic [SRC_W-1:0] src_less1(input logic [CFG_W-1:0] v);
      logic [SRC_W-1:0] r;
      if (int'(v) < MIN_DIM) begin
         r = SRC_W'(MIN_DIM - 1);
      end else if (int'(v) >= MAX_SRC_DIM) begin
         r = SRC_W'(MAX_SRC_DIM - 1);
      end else begin
         r = SRC_W'(v - CFG_W'(1));
      end
      return r;
   endfunction

   function automatic logic [OUT_W-1:0] out_span(input logic [CFG_W-1:0] v);
      logic [OUT_W-1:0] r;
      if (int'(v) < MIN_DIM) begin
         r = OUT_W'(MIN_DIM - 1);
      end else if (int'(v) >= MAX_OUT_DIM) begin
         r = OUT_W'(MAX_OUT_DIM - 1);
      end else begin
         r = OUT_W'(v - CFG_W'(1));
      end
      return r;
   endfunction

endpackage

FILE: rtl/nearest_neighbor_image_scaler_core.sv
// Top level of the nearest-neighbor scaler: configuration registers, input
// stage, mapping pipeline and the frame store. Depends on nns_pkg, nns_map
// and assert_macros.svh.
//
// Usage. A request word is taken at each rising edge where start is high and
// busy is low; busy stays low, so one word can enter every cycle. A word with
// action low loads pixel_in into the frame store at (row, col); rows or columns
// beyond the store are dropped and give no result. A word with action high
// asks for the output pixel at (row, col) and gives one result word.
// Results come out on rsp_data for exactly one cycle with rsp_strobe high,
// after one input stage, two stages for the multiply and numerator, one divider
// stage per source coordinate bit (9), and the registered frame store read.
// The receiver cannot hold results off.
// Loads and requests keep their order, so a request sees every earlier load.
// Sizes are written on the csr channel, which is always ready, while no word
// is in flight. Reset sets the sizes to 512 x 512 in, 768 x 768 out and
// empties the pipeline; the frame store is not cleared and must be loaded
// before it is read.
`include "assert_macros.svh"

module nearest_neighbor_image_scaler_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  nns_pkg::nns_req_type             req_data,
   output logic                             rsp_strobe,
   output nns_pkg::nns_rsp_type             rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [nns_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nns_pkg::CFG_W-1:0]        csr_data
);
   import nns_pkg::*;

   logic [SRC_W-1:0] src_w_m1_ff;
   logic [SRC_W-1:0] src_h_m1_ff;
   logic [OUT_W-1:0] out_w_span_ff;
   logic [OUT_W-1:0] out_h_span_ff;

   nns_side_type                   side_a_in;
   nns_side_type                   side_a_ff;
   nns_lane_type [LANES-1:0]       lane_a_in;
   nns_lane_type [LANES-1:0]       lane_a_ff;

   nns_side_type                   map_side;
   logic [LANES-1:0][SRC_W-1:0]    map_quo;
   logic [ADDR_W-1:0]              rd_addr;

   logic [PIX_W-1:0]               frame_mem [STORE_DEPTH];
   logic [PIX_W-1:0]               rd_pixel_ff;
   logic [SRC_W-1:0]               rsp_row_ff;
   logic [SRC_W-1:0]               rsp_col_ff;
   logic                           rsp_strobe_ff;

   function automatic logic [OUT_W-1:0] clamp_coord(input logic [COORD_W-1:0] v,
                                                    input logic [OUT_W-1:0]   span);
      logic [OUT_W-1:0] r;
      if ((COORD_W + OUT_W)'(v) > (COORD_W + OUT_W)'(span)) begin
         r = span;
      end else begin
         r = OUT_W'(v);
      end
      return r;
   endfunction

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_m1_ff   <= src_less1(CFG_W'(SRC_RESET));
         src_h_m1_ff   <= src_less1(CFG_W'(SRC_RESET));
         out_w_span_ff <= out_span(CFG_W'(OUT_RESET));
         out_h_span_ff <= out_span(CFG_W'(OUT_RESET));
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SRC_WIDTH:  src_w_m1_ff   <= src_less1(csr_data);
            CSR_SRC_HEIGHT: src_h_m1_ff   <= src_less1(csr_data);
            CSR_OUT_WIDTH:  out_w_span_ff <= out_span(csr_data);
            CSR_OUT_HEIGHT: out_h_span_ff <= out_span(csr_data);
            default: ;
         endcase
      end
   end

   always_comb begin
      side_a_in.valid   = start && !busy;
      side_a_in.is_load = (req_data.action == ACT_LOAD);
      side_a_in.wr_ok   = (int'(req_data.row) < MAX_SRC_DIM) &&
                          (int'(req_data.col) < MAX_SRC_DIM);
      side_a_in.waddr   = ADDR_W'(req_data.row) * ADDR_W'(MAX_SRC_DIM) +
                          ADDR_W'(req_data.col);
      side_a_in.pixel   = req_data.pixel_in;

      lane_a_in[LANE_ROW].o    = clamp_coord(req_data.row, out_h_span_ff);
      lane_a_in[LANE_ROW].sm1  = src_h_m1_ff;
      lane_a_in[LANE_ROW].span = out_h_span_ff;
      lane_a_in[LANE_COL].o    = clamp_coord(req_data.col, out_w_span_ff);
      lane_a_in[LANE_COL].sm1  = src_w_m1_ff;
      lane_a_in[LANE_COL].span = out_w_span_ff;
   end

   always_ff @(posedge clock) begin
      side_a_ff <= side_a_in;
      lane_a_ff <= lane_a_in;
      if (reset) begin
         side_a_ff.valid <= 1'b0;
      end
   end

   nns_map u_map (
      .clock    (clock),
      .reset    (reset),
      .side_in  (side_a_ff),
      .lane_in  (lane_a_ff),
      .side_out (map_side),
      .quo_out  (map_quo)
   );

   assign rd_addr = ADDR_W'(map_quo[LANE_ROW]) * ADDR_W'(MAX_SRC_DIM) +
                    ADDR_W'(map_quo[LANE_COL]);

   // Loads write and requests read at the same stage, so order is kept.
   always_ff @(posedge clock) begin
      if (map_side.valid && map_side.is_load && map_side.wr_ok) begin
         frame_mem[map_side.waddr] <= map_side.pixel;
      end
      rd_pixel_ff <= frame_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rsp_row_ff <= map_quo[LANE_ROW];
      rsp_col_ff <= map_quo[LANE_COL];
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= map_side.valid && !map_side.is_load;
      end
   end

   assign rsp_strobe             = rsp_strobe_ff;
   assign rsp_data.pixel_out     = rd_pixel_ff;
   assign rsp_data.src_row_used  = rsp_row_ff;
   assign rsp_data.src_col_used  = rsp_col_ff;

   `ASSERT_NEXT(a_load_silent, clock, reset, map_side.valid && map_side.is_load, !rsp_strobe)
   `ASSERT_NEXT(a_read_answers, clock, reset, map_side.valid && !map_side.is_load, rsp_strobe)
   `ASSERT_NEXT(a_idle_silent, clock, reset, !map_side.valid, !rsp_strobe)

endmodule

FILE: rtl/nns_map.sv
// Coordinate mapping pipeline: multiply, numerator build and a restoring
// divider that settles one quotient bit per stage, row and column side by side.
// Depends on nns_pkg and assert_macros.svh.
`include "assert_macros.svh"

module nns_map (
   input  logic                                          clock,
   input  logic                                          reset,
   input  nns_pkg::nns_side_type                         side_in,
   input  nns_pkg::nns_lane_type [nns_pkg::LANES-1:0]    lane_in,
   output nns_pkg::nns_side_type                         side_out,
   output logic [nns_pkg::LANES-1:0][nns_pkg::SRC_W-1:0] quo_out
);
   import nns_pkg::*;

   nns_side_type                     side_m0_ff;
   logic [LANES-1:0][PROD_W-1:0]     prod_m0_ff;
   logic [LANES-1:0][OUT_W-1:0]      span_m0_ff;

   logic [LANES-1:0][NUM_W-1:0]      num_in;
   nns_side_type                     side_m1_ff;
   logic [LANES-1:0][DEN_W-1:0]      rem_m1_ff;
   logic [LANES-1:0][DEN_W-1:0]      den_m1_ff;
   logic [LANES-1:0][SRC_W-1:0]      nlo_m1_ff;

   nns_side_type                     side_ff [SRC_W];
   logic [LANES-1:0][DEN_W-1:0]      rem_ff  [SRC_W];
   logic [LANES-1:0][DEN_W-1:0]      den_ff  [SRC_W];
   logic [LANES-1:0][SRC_W-1:0]      nlo_ff  [SRC_W];
   logic [LANES-1:0][SRC_W-1:0]      quo_ff  [SRC_W];

   nns_side_type                     side_pv [SRC_W];
   logic [LANES-1:0][DEN_W-1:0]      rem_pv  [SRC_W];
   logic [LANES-1:0][DEN_W-1:0]      den_pv  [SRC_W];
   logic [LANES-1:0][SRC_W-1:0]      nlo_pv  [SRC_W];
   logic [LANES-1:0][SRC_W-1:0]      quo_pv  [SRC_W];

   logic [LANES-1:0][DEN_W-1:0]      rem_in  [SRC_W];
   logic [LANES-1:0][SRC_W-1:0]      nlo_in  [SRC_W];
   logic [LANES-1:0][SRC_W-1:0]      quo_in  [SRC_W];

   always_ff @(posedge clock) begin
      side_m0_ff <= side_in;
      for (int l = 0; l < LANES; l++) begin
         prod_m0_ff[l] <= PROD_W'(lane_in[l].o) * PROD_W'(lane_in[l].sm1);
         span_m0_ff[l] <= lane_in[l].span;
      end
      if (reset) begin
         side_m0_ff.valid <= 1'b0;
      end
   end

   // The numerator is 2*o*(S-1) + (O-1) and the divisor 2*(O-1).
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         num_in[l] = {prod_m0_ff[l], 1'b0} + NUM_W'(span_m0_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      side_m1_ff <= side_m0_ff;
      for (int l = 0; l < LANES; l++) begin
         rem_m1_ff[l] <= num_in[l][NUM_W-1:SRC_W];
         nlo_m1_ff[l] <= num_in[l][SRC_W-1:0];
         den_m1_ff[l] <= {span_m0_ff[l], 1'b0};
      end
      if (reset) begin
         side_m1_ff.valid <= 1'b0;
      end
   end

   always_comb begin
      side_pv[0] = side_m1_ff;
      rem_pv[0]  = rem_m1_ff;
      den_pv[0]  = den_m1_ff;
      nlo_pv[0]  = nlo_m1_ff;
      quo_pv[0]  = '0;
      for (int k = 1; k < SRC_W; k++) begin
         side_pv[k] = side_ff[k-1];
         rem_pv[k]  = rem_ff[k-1];
         den_pv[k]  = den_ff[k-1];
         nlo_pv[k]  = nlo_ff[k-1];
         quo_pv[k]  = quo_ff[k-1];
      end
   end

   // Each stage brings down the next numerator bit and subtracts the divisor
   // when it fits, giving one quotient bit.
   always_comb begin
      logic [DEN_W:0] trial;
      logic           qbit;
      for (int k = 0; k < SRC_W; k++) begin
         for (int l = 0; l < LANES; l++) begin
            trial = {rem_pv[k][l], nlo_pv[k][l][SRC_W-1]};
            if (trial >= {1'b0, den_pv[k][l]}) begin
               rem_in[k][l] = DEN_W'(trial - {1'b0, den_pv[k][l]});
               qbit = 1'b1;
            end else begin
               rem_in[k][l] = DEN_W'(trial);
               qbit = 1'b0;
            end
            nlo_in[k][l] = nlo_pv[k][l] << 1;
            quo_in[k][l] = SRC_W'({quo_pv[k][l], qbit});
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SRC_W; k++) begin
         side_ff[k] <= side_pv[k];
         rem_ff[k]  <= rem_in[k];
         den_ff[k]  <= den_pv[k];
         nlo_ff[k]  <= nlo_in[k];
         quo_ff[k]  <= quo_in[k];
      end
      if (reset) begin
         for (int k = 0; k < SRC_W; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end
   end

   assign side_out = side_ff[SRC_W-1];
   assign quo_out  = quo_ff[SRC_W-1];

   `ASSERT_ALWAYS(a_row_rem_start, clock, reset, side_m1_ff.valid |-> rem_m1_ff[LANE_ROW] < den_m1_ff[LANE_ROW])
   `ASSERT_ALWAYS(a_col_rem_start, clock, reset, side_m1_ff.valid |-> rem_m1_ff[LANE_COL] < den_m1_ff[LANE_COL])
   `ASSERT_ALWAYS(a_row_rem_end, clock, reset, side_ff[SRC_W-1].valid |-> rem_ff[SRC_W-1][LANE_ROW] < den_ff[SRC_W-1][LANE_ROW])
   `ASSERT_ALWAYS(a_col_rem_end, clock, reset, side_ff[SRC_W-1].valid |-> rem_ff[SRC_W-1][LANE_COL] < den_ff[SRC_W-1][LANE_COL])

endmodule

FILE: sim/tb.sv
// Self-checking testbench for nearest_neighbor_image_scaler_core.
// Drives load and request words, predicts every result with its own frame model.
// Depends on nns_pkg and the scaler RTL.
`timescale 1ns / 100ps

module tb;
   import nns_pkg::*;

   localparam int DRAIN_CYCLES = 20;
   localparam int QUIET_LIMIT  = 2000;
   localparam int PRINT_LIMIT  = 100;

   logic          clock = 1'b0;
   logic          reset;
   logic          start;
   logic          busy;
   nns_req_type   req_data;
   logic          rsp_strobe;
   nns_rsp_type   rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_data;

   logic [PIX_W-1:0] frame_model [0:STORE_DEPTH-1];
   bit               frame_loaded [0:STORE_DEPTH-1];
   logic [CFG_W-1:0] cfg_src_width;
   logic [CFG_W-1:0] cfg_src_height;
   logic [CFG_W-1:0] cfg_out_width;
   logic [CFG_W-1:0] cfg_out_height;
   nns_rsp_type      pending_pixels [$];
   int               error_count = 0;
   int               words_sent = 0;
   int               idle_pct = 0;
   int               quiet_cycles = 0;

   nearest_neighbor_image_scaler_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT) begin
         $display("tb: mismatch at %0t ns: %s", $time, msg);
      end
      error_count++;
   endtask

   function automatic int clamp_size(input logic [CFG_W-1:0] v, input int hi);
      int r;
      r = int'(v);
      if (r < MIN_DIM) begin
         r = MIN_DIM;
      end else if (r > hi) begin
         r = hi;
      end
      return r;
   endfunction

   function automatic int map_axis(input int o, input logic [CFG_W-1:0] s_reg,
                                   input logic [CFG_W-1:0] o_reg);
      int s;
      int span;
      s = clamp_size(s_reg, MAX_SRC_DIM);
      span = clamp_size(o_reg, MAX_OUT_DIM) - 1;
      if (o > span) begin
         o = span;
      end
      return (2 * o * (s - 1) + span) / (2 * span);
   endfunction

   function automatic void apply_to_frame_model(input nns_req_type w);
      nns_rsp_type r;
      int mr;
      int mc;
      if (w.action == ACT_LOAD) begin
         if (int'(w.row) < MAX_SRC_DIM && int'(w.col) < MAX_SRC_DIM) begin
            frame_model[int'(w.row) * MAX_SRC_DIM + int'(w.col)] = w.pixel_in;
            frame_loaded[int'(w.row) * MAX_SRC_DIM + int'(w.col)] = 1'b1;
         end
      end else begin
         mr = map_axis(int'(w.row), cfg_src_height, cfg_out_height);
         mc = map_axis(int'(w.col), cfg_src_width, cfg_out_width);
         r.pixel_out    = frame_model[mr * MAX_SRC_DIM + mc];
         r.src_row_used = SRC_W'(mr);
         r.src_col_used = SRC_W'(mc);
         pending_pixels.push_back(r);
      end
   endfunction

   function automatic nns_req_type make_word(input logic act, input int r, input int c,
                                             input int p);
      nns_req_type w;
      w.action   = act;
      w.row      = COORD_W'(r);
      w.col      = COORD_W'(c);
      w.pixel_in = PIX_W'(p);
      return w;
   endfunction

   task automatic send_word(input nns_req_type w);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start    <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy);
      apply_to_frame_model(w);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic load_pixel(input int r, input int c, input int p);
      send_word(make_word(ACT_LOAD, r, c, p));
   endtask

   // The mapped entry is loaded first when it has never been written.
   task automatic read_output(input int orow, input int ocol);
      int mr;
      int mc;
      mr = map_axis(orow, cfg_src_height, cfg_out_height);
      mc = map_axis(ocol, cfg_src_width, cfg_out_width);
      if (!frame_loaded[mr * MAX_SRC_DIM + mc]) begin
         load_pixel(mr, mc, $urandom_range(255));
      end
      send_word(make_word(ACT_READ, orow, ocol, $urandom_range(255)));
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (pending_pixels.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CFG_W-1:0] v);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SRC_WIDTH:  cfg_src_width  = v;
         CSR_SRC_HEIGHT: cfg_src_height = v;
         CSR_OUT_WIDTH:  cfg_out_width  = v;
         CSR_OUT_HEIGHT: cfg_out_height = v;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_sizes(input int sw, input int sh, input int ow, input int oh);
      wait_idle();
      csr_write(CSR_SRC_WIDTH, CFG_W'(sw));
      csr_write(CSR_SRC_HEIGHT, CFG_W'(sh));
      csr_write(CSR_OUT_WIDTH, CFG_W'(ow));
      csr_write(CSR_OUT_HEIGHT, CFG_W'(oh));
      csr_valid <= 1'b0;
   endtask

   function automatic int pick_size(input int hi);
      int r;
      r = $urandom_range(99);
      if (r < 15) begin
         return MIN_DIM;
      end else if (r < 30) begin
         return hi;
      end else if (r < 40) begin
         if (hi == MAX_SRC_DIM && $urandom_range(1)) begin
            return $urandom_range(MAX_SRC_DIM + 1, (1 << CFG_W) - 1);
         end
         return $urandom_range(1);
      end else if (r < 75) begin
         return $urandom_range(MIN_DIM, 24);
      end
      return $urandom_range(MIN_DIM, hi);
   endfunction

   task automatic random_traffic(input int count);
      int goal;
      int r;
      int orow;
      int ocol;
      int hspan;
      int wspan;
      int shgt;
      int swid;
      goal  = words_sent + count;
      hspan = clamp_size(cfg_out_height, MAX_OUT_DIM) - 1;
      wspan = clamp_size(cfg_out_width, MAX_OUT_DIM) - 1;
      shgt  = clamp_size(cfg_src_height, MAX_SRC_DIM);
      swid  = clamp_size(cfg_src_width, MAX_SRC_DIM);
      while (words_sent < goal) begin
         r = $urandom_range(99);
         orow = $urandom_range(hspan);
         ocol = $urandom_range(wspan);
         if (r < 45) begin
            read_output(orow, ocol);
         end else if (r < 55) begin
            read_output($urandom_range(1022), $urandom_range(1022));
         end else if (r < 70) begin
            load_pixel(map_axis(orow, cfg_src_height, cfg_out_height),
                       map_axis(ocol, cfg_src_width, cfg_out_width), $urandom_range(255));
            read_output(orow, ocol);
         end else if (r < 90) begin
            load_pixel($urandom_range(shgt - 1), $urandom_range(swid - 1),
                       $urandom_range(255));
         end else begin
            load_pixel($urandom_range(1022), $urandom_range(1022), $urandom_range(255));
         end
      end
   endtask

   task automatic test_reset_sizes();
      idle_pct = 0;
      load_pixel(0, 0, 8'h5A);
      load_pixel(511, 511, 8'hFF);
      load_pixel(0, 511, 8'h00);
      load_pixel(511, 0, 8'hA5);
      load_pixel(1, 0, 8'h3C);
      load_pixel(512, 0, 8'hFF);
      load_pixel(0, 1022, 8'hFF);
      read_output(0, 0);
      read_output(767, 767);
      read_output(0, 767);
      read_output(767, 0);
      read_output(1022, 1022);
      read_output(1, 0);
   endtask

   // Writes to indexes with no register behind them must leave the sizes alone.
   task automatic test_unknown_index();
      wait_idle();
      for (int i = 4; i < (1 << CSR_IDX_W); i++) begin
         csr_valid <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_data  <= CFG_W'($urandom_range(1023));
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid <= 1'b0;
      idle_pct = 0;
      random_traffic(40);
   endtask

   task automatic test_smallest_sizes();
      set_sizes(MIN_DIM, MIN_DIM, MIN_DIM, MIN_DIM);
      read_output(0, 0);
      read_output(1, 1);
      read_output(0, 1);
      read_output(1022, 0);
      set_sizes(MIN_DIM, MIN_DIM, 3, 3);
      read_output(1, 1);
      read_output(2, 0);
   endtask

   task automatic test_largest_sizes();
      set_sizes(MAX_SRC_DIM, MAX_SRC_DIM, MAX_OUT_DIM, MAX_OUT_DIM);
      idle_pct = 58;
      random_traffic(200);
   endtask

   task automatic test_out_of_range_sizes();
      set_sizes(0, 1023, 1, 0);
      idle_pct = 20;
      random_traffic(100);
      set_sizes(1, 600, 0, 1);
      idle_pct = 0;
      random_traffic(100);
   endtask

   task automatic test_random_sizes();
      for (int ph = 0; ph < 5; ph++) begin
         set_sizes(pick_size(MAX_SRC_DIM), pick_size(MAX_SRC_DIM),
                   pick_size(MAX_OUT_DIM), pick_size(MAX_OUT_DIM));
         case (ph % 3)
            0: idle_pct = 0;
            1: idle_pct = 58;
            default: idle_pct = 20;
         endcase
         random_traffic(180);
      end
   endtask

   always @(posedge clock) begin
      nns_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_pixels.size() == 0) begin
            report_error("result word with no request outstanding");
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_data.pixel_out !== want.pixel_out) begin
               report_error($sformatf("pixel_out got %h want %h",
                                      rsp_data.pixel_out, want.pixel_out));
            end
            if (rsp_data.src_row_used !== want.src_row_used) begin
               report_error($sformatf("src_row_used got %0d want %0d",
                                      rsp_data.src_row_used, want.src_row_used));
            end
            if (rsp_data.src_col_used !== want.src_col_used) begin
               report_error($sformatf("src_col_used got %0d want %0d",
                                      rsp_data.src_col_used, want.src_col_used));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_index      = CSR_SRC_WIDTH;
      csr_data       = '0;
      cfg_src_width  = CFG_W'(SRC_RESET);
      cfg_src_height = CFG_W'(SRC_RESET);
      cfg_out_width  = CFG_W'(OUT_RESET);
      cfg_out_height = CFG_W'(OUT_RESET);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_reset_sizes();
      test_unknown_index();
      test_smallest_sizes();
      test_largest_sizes();
      test_out_of_range_sizes();
      test_random_sizes();
      wait_idle();
      if (error_count == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
